FILE: design/tlsm_pkg.sv
// ----------------------------------------------------------------------------
// tlsm_pkg
// Shared types and constants for the two-list sorted merge block: operation
// codes, sequencer states and the buffer control bundle.
// ----------------------------------------------------------------------------
package tlsm_pkg;

    // width of one stored element
    localparam int DATA_W = 32;

    // operation codes carried by an input item
    localparam logic [1:0] OP_APPEND_A = 2'd0;
    localparam logic [1:0] OP_APPEND_B = 2'd1;
    localparam logic [1:0] OP_MERGE    = 2'd2;

    // merge sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } t_state;

    // control from the sequencer to one list buffer
    typedef struct packed {
        logic push;
        logic clear;
    } t_buf_ctrl;

endpackage

FILE: design/tlsm_list_buf.sv
// ----------------------------------------------------------------------------
// tlsm_list_buf
// One list buffer: element memory with one write and one registered read
// port, plus the fill count. Pushes to a full buffer are dropped.
// ----------------------------------------------------------------------------
module tlsm_list_buf #(
    parameter int LIST_DEPTH = 32,
    localparam int CNT_W = $clog2(LIST_DEPTH + 1),
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tlsm_pkg::t_buf_ctrl                 i_ctrl,
    input  logic signed [tlsm_pkg::DATA_W-1:0]  i_wr_data,
    input  logic        [IDX_W-1:0]             i_rd_idx,
    output logic signed [tlsm_pkg::DATA_W-1:0]  o_rd_data,
    output logic        [CNT_W-1:0]             o_count
);

    logic signed [tlsm_pkg::DATA_W-1:0] r_mem [LIST_DEPTH];
    logic signed [tlsm_pkg::DATA_W-1:0] r_rd_data;
    logic        [CNT_W-1:0]            r_count;
    logic        [CNT_W-1:0]            n_count;
    logic                               wr_en;

    // push only while there is room
    assign wr_en = i_ctrl.push && (r_count < CNT_W'(LIST_DEPTH));

    // element memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    // fill count
    always_comb begin
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_count = '0;
        end else if (wr_en) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

endmodule

FILE: design/two_list_sorted_merge_top.sv
// Sequence: an append is written straight into its buffer; a merge leaves ST_IDLE,
// then alternates ST_FETCH (buffer read) and ST_EMIT (compare and emit) per element.
// Throughput: one append per cycle while no merge is running; a merge holds
// the input until its last element is emitted, longer while the output is stalled.
// Reset clears both list counts, the sequencer and the output valid; buffer
// contents are undefined until written.
// ----------------------------------------------------------------------------
// two_list_sorted_merge_top
// Loads two ascending lists into buffers and merges them on request, one
// element per result item, with a single shared signed compare.
// ----------------------------------------------------------------------------
module two_list_sorted_merge_top #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic        [1:0]                   i_operation,
    input  logic signed [tlsm_pkg::DATA_W-1:0]  i_element_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tlsm_pkg::DATA_W-1:0]  o_merged_value,
    output logic                                o_is_last
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    tlsm_pkg::t_state                   r_state, n_state;
    logic        [CNT_W-1:0]            r_ia, n_ia;
    logic        [CNT_W-1:0]            r_ib, n_ib;
    logic                               r_out_valid, n_out_valid;
    logic signed [tlsm_pkg::DATA_W-1:0] r_out_value, n_out_value;
    logic                               r_out_last, n_out_last;

    tlsm_pkg::t_buf_ctrl                ctrl_a, ctrl_b;
    logic signed [tlsm_pkg::DATA_W-1:0] rd_a, rd_b;
    logic        [CNT_W-1:0]            cnt_a, cnt_b;
    logic                               in_acc;
    logic                               out_free;
    logic                               a_left, b_left, take_a;

    // list buffers
    tlsm_list_buf #(.LIST_DEPTH(LIST_DEPTH)) u_buf_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl_a),
        .i_wr_data (i_element_value),
        .i_rd_idx  (r_ia[IDX_W-1:0]),
        .o_rd_data (rd_a),
        .o_count   (cnt_a)
    );

    tlsm_list_buf #(.LIST_DEPTH(LIST_DEPTH)) u_buf_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl_b),
        .i_wr_data (i_element_value),
        .i_rd_idx  (r_ib[IDX_W-1:0]),
        .o_rd_data (rd_b),
        .o_count   (cnt_b)
    );

    // handshakes
    assign o_in_stall = (r_state != tlsm_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // shared head compare: a wins only when strictly less, b wins ties
    assign a_left = (r_ia < cnt_a);
    assign b_left = (r_ib < cnt_b);
    assign take_a = a_left && (!b_left || (rd_a < rd_b));

    // sequencer next state and outputs
    always_comb begin
        n_state     = r_state;
        n_ia        = r_ia;
        n_ib        = r_ib;
        ctrl_a      = '0;
        ctrl_b      = '0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        unique case (r_state)
            tlsm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_operation)
                        tlsm_pkg::OP_APPEND_A: ctrl_a.push = 1'b1;
                        tlsm_pkg::OP_APPEND_B: ctrl_b.push = 1'b1;
                        tlsm_pkg::OP_MERGE: begin
                            if ((cnt_a != '0) || (cnt_b != '0)) begin
                                n_ia    = '0;
                                n_ib    = '0;
                                n_state = tlsm_pkg::ST_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            tlsm_pkg::ST_FETCH: begin
                n_state = tlsm_pkg::ST_EMIT;
            end
            tlsm_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (take_a) begin
                        n_out_value = rd_a;
                        n_ia        = r_ia + CNT_W'(1);
                    end else begin
                        n_out_value = rd_b;
                        n_ib        = r_ib + CNT_W'(1);
                    end
                    n_out_last = (n_ia == cnt_a) && (n_ib == cnt_b);
                    if (n_out_last) begin
                        ctrl_a.clear = 1'b1;
                        ctrl_b.clear = 1'b1;
                        n_state      = tlsm_pkg::ST_IDLE;
                    end else begin
                        n_state = tlsm_pkg::ST_FETCH;
                    end
                end
            end
            default: n_state = tlsm_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlsm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // indexes and output payload
    always_ff @(posedge i_clk) begin
        r_ia        <= n_ia;
        r_ib        <= n_ib;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_value;
    assign o_is_last      = r_out_last;

endmodule
